### rtl/core/kst_pkg.sv
// Shared types and constants for the keyed slot table core.
package kst_pkg;

  localparam int SLOTS_DEFAULT = 16;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_SEARCH  = 3'd2,
    CMD_SORT    = 3'd3,
    CMD_BSEARCH = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_NOSORT   = 3'd4,
    STAT_INVALID  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_SHIFT,
    ST_SHIFT_WR,
    ST_SORT_LOAD,
    ST_SORT_HOLD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_END,
    ST_BS,
    ST_BS_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [63:0]        key;
    logic [63:0]        tag;
    logic signed [31:0] quantity;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         found_index;
    logic [4:0]         compare_count;
    logic [63:0]        found_tag;
    logic signed [31:0] found_quantity;
    logic [4:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [63:0]        tag;
    logic signed [31:0] quantity;
  } slot_rec_t;

endpackage

### rtl/core/kst_ram.sv
// Generic single write port RAM with one registered read port.
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/keyed_slot_table_sort_search_core.sv
// Keyed slot table: insert, remove, linear search, bubble sort, binary search.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------
//  req     | in        | req_valid/stall  | cmd, key, tag, quantity
//  rsp     | out       | rsp_valid/stall  | status, index, compares, tag, qty,
//          |           |                  | entry_count
//
// One command at a time; req_stall is high from acceptance until the result
// is loaded into the rsp register. Every slot visit sets the address, then
// compares on the registered read of the single record RAM. Reset clears the
// entry count, state and rsp_valid only; no clearing pass.
// A stalled rsp beat holds; the next command may be taken meanwhile.
module keyed_slot_table_sort_search_core #(
  parameter int SLOTS = kst_pkg::SLOTS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  kst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output kst_pkg::rsp_t rsp
);
  import kst_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = $bits(slot_rec_t);

  state_t             state, state_next;
  logic [2:0]         cmd, cmd_next;
  logic [63:0]        key, key_next;
  logic [63:0]        tag, tag_next;
  logic signed [31:0] qty, qty_next;
  logic [CW-1:0]      occ, occ_next;
  logic [CW-1:0]      i, i_next;
  logic [CW-1:0]      cmps, cmps_next;
  logic [CW-1:0]      lo, lo_next;
  logic [CW-1:0]      hi_ex, hi_ex_next;
  logic [CW-1:0]      lim, lim_next;
  slot_rec_t          hold, hold_next;
  status_t            stat, stat_next;
  logic [IW-1:0]      res_idx, res_idx_next;
  logic [63:0]        res_tag, res_tag_next;
  logic signed [31:0] res_qty, res_qty_next;
  logic               rsp_valid_next;
  rsp_t               rsp_next;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  slot_rec_t          mem_wdata;
  logic [IW-1:0]      mem_raddr;
  logic [RW-1:0]      mem_rdata;
  slot_rec_t          rd;

  logic               req_take;
  logic [CW:0]        i_inc;
  logic [CW:0]        mid_sum;
  logic               search_cmd;

  kst_ram #(
    .WIDTH(RW),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd         = slot_rec_t'(mem_rdata);
  assign req_stall  = (state != ST_IDLE);
  assign req_take   = req_valid && !req_stall;
  assign i_inc      = {1'b0, i} + {{CW{1'b0}}, 1'b1};
  assign mid_sum    = ({1'b0, lo} + {1'b0, hi_ex} - {{CW{1'b0}}, 1'b1}) >> 1;
  assign search_cmd = (cmd == CMD_SEARCH) || (cmd == CMD_BSEARCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      rsp_valid <= rsp_valid_next;
    end
    cmd     <= cmd_next;
    key     <= key_next;
    tag     <= tag_next;
    qty     <= qty_next;
    i       <= i_next;
    cmps    <= cmps_next;
    lo      <= lo_next;
    hi_ex   <= hi_ex_next;
    lim     <= lim_next;
    hold    <= hold_next;
    stat    <= stat_next;
    res_idx <= res_idx_next;
    res_tag <= res_tag_next;
    res_qty <= res_qty_next;
    rsp     <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    key_next       = key;
    tag_next       = tag;
    qty_next       = qty;
    occ_next       = occ;
    i_next         = i;
    cmps_next      = cmps;
    lo_next        = lo;
    hi_ex_next     = hi_ex;
    lim_next       = lim;
    hold_next      = hold;
    stat_next      = stat;
    res_idx_next   = res_idx;
    res_tag_next   = res_tag;
    res_qty_next   = res_qty;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    mem_we         = 1'b0;
    mem_waddr      = i[IW-1:0];
    mem_wdata      = rd;
    mem_raddr      = i[IW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          cmd_next     = req.cmd;
          key_next     = req.key;
          tag_next     = req.tag;
          qty_next     = req.quantity;
          i_next       = '0;
          cmps_next    = '0;
          lo_next      = '0;
          hi_ex_next   = occ;
          lim_next     = occ - CW'(1);
          stat_next    = STAT_OK;
          res_idx_next = '0;
          res_tag_next = '0;
          res_qty_next = '0;
          unique case (req.cmd)
            CMD_INSERT: begin
              if (req.key[63:56] == 8'd0) begin
                stat_next  = STAT_INVALID;
                state_next = ST_DONE;
              end else begin
                state_next = ST_SCAN;
              end
            end
            CMD_REMOVE, CMD_SEARCH: state_next = ST_SCAN;
            CMD_SORT: begin
              if (occ <= CW'(1)) begin
                stat_next  = STAT_NOSORT;
                state_next = ST_DONE;
              end else begin
                state_next = ST_SORT_LOAD;
              end
            end
            CMD_BSEARCH: state_next = ST_BS;
            default:     state_next = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        if (i < occ) begin
          mem_raddr  = i[IW-1:0];
          state_next = ST_SCAN_CMP;
        end else if (cmd == CMD_INSERT) begin
          if (occ >= CW'(SLOTS)) begin
            stat_next = STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = occ[IW-1:0];
            mem_wdata = '{key: key, tag: tag, quantity: qty};
            occ_next  = occ + CW'(1);
          end
          state_next = ST_DONE;
        end else begin
          stat_next  = STAT_NOTFOUND;
          state_next = ST_DONE;
        end
      end

      ST_SCAN_CMP: begin
        cmps_next = cmps + CW'(1);
        if (rd.key == key) begin
          if (cmd == CMD_INSERT) begin
            stat_next  = STAT_DUP;
            state_next = ST_DONE;
          end else if (cmd == CMD_REMOVE) begin
            state_next = ST_SHIFT;
          end else begin
            res_idx_next = i[IW-1:0];
            res_tag_next = rd.tag;
            res_qty_next = rd.quantity;
            state_next   = ST_DONE;
          end
        end else begin
          i_next     = i_inc[CW-1:0];
          state_next = ST_SCAN;
        end
      end

      // pull the later records down one slot
      ST_SHIFT: begin
        if (i_inc < {1'b0, occ}) begin
          mem_raddr  = i_inc[IW-1:0];
          state_next = ST_SHIFT_WR;
        end else begin
          occ_next   = occ - CW'(1);
          state_next = ST_DONE;
        end
      end

      ST_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = i[IW-1:0];
        mem_wdata  = rd;
        i_next     = i_inc[CW-1:0];
        state_next = ST_SHIFT;
      end

      // one bubble pass: the larger record is carried in hold
      ST_SORT_LOAD: begin
        mem_raddr  = '0;
        i_next     = '0;
        state_next = ST_SORT_HOLD;
      end

      ST_SORT_HOLD: begin
        hold_next  = rd;
        state_next = ST_SORT_RD;
      end

      ST_SORT_RD: begin
        mem_raddr  = i_inc[IW-1:0];
        state_next = ST_SORT_CMP;
      end

      ST_SORT_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = i[IW-1:0];
        if (hold.key > rd.key) begin
          mem_wdata = rd;
        end else begin
          mem_wdata = hold;
          hold_next = rd;
        end
        i_next = i_inc[CW-1:0];
        if (i_inc < {1'b0, lim}) begin
          state_next = ST_SORT_RD;
        end else begin
          state_next = ST_SORT_END;
        end
      end

      ST_SORT_END: begin
        mem_we    = 1'b1;
        mem_waddr = i[IW-1:0];
        mem_wdata = hold;
        lim_next  = lim - CW'(1);
        if (lim == CW'(1)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SORT_LOAD;
        end
      end

      // halving over [lo, hi_ex)
      ST_BS: begin
        if (lo < hi_ex) begin
          i_next     = mid_sum[CW-1:0];
          mem_raddr  = mid_sum[IW-1:0];
          state_next = ST_BS_CMP;
        end else begin
          stat_next  = STAT_NOTFOUND;
          state_next = ST_DONE;
        end
      end

      ST_BS_CMP: begin
        cmps_next = cmps + CW'(1);
        if (rd.key == key) begin
          res_idx_next = i[IW-1:0];
          res_tag_next = rd.tag;
          res_qty_next = rd.quantity;
          state_next   = ST_DONE;
        end else begin
          if (rd.key > key) begin
            hi_ex_next = i;
          end else begin
            lo_next = i_inc[CW-1:0];
          end
          state_next = ST_BS;
        end
      end

      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next.status         = stat;
          rsp_next.found_index    = 4'(res_idx);
          rsp_next.compare_count  = search_cmd ? 5'(cmps) : 5'd0;
          rsp_next.found_tag      = res_tag;
          rsp_next.found_quantity = res_qty;
          rsp_next.entry_count    = 5'(occ);
          rsp_valid_next          = 1'b1;
          state_next              = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### sim/keyed_slot_table_sort_search_core_tb.sv
// Self-checking testbench for the keyed slot table core: shadow table predictor and scoreboard.
`timescale 1ns / 100ps

module keyed_slot_table_sort_search_core_tb;
  import kst_pkg::*;

  localparam int SLOTS          = SLOTS_DEFAULT;
  localparam int POOL_SIZE      = 20;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 350;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 400;

  typedef struct {
    req_t beat;
    bit   drain;
  } queued_cmd_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  queued_cmd_t cmd_backlog [$];
  queued_cmd_t next_cmd;
  rsp_t        predicted_rsp [$];
  rsp_t        want;

  slot_rec_t   shadow_slots [SLOTS];
  int          shadow_count = 0;

  logic [63:0] key_pool [POOL_SIZE];
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          real_items    = 0;
  bit          drain_next    = 1'b0;
  bit          req_fired     = 1'b0;
  int          quiet_cycles  = 0;
  int          error_count   = 0;

  int phase_send_idle [PHASES] = '{0, 80, 0, 30, 0};
  int phase_stall     [PHASES] = '{0, 0, 80, 30, 0};

  keyed_slot_table_sort_search_core #(.SLOTS(SLOTS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pool_key();
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic int find_linear(logic [63:0] k, output int cmps);
    int i;
    cmps = 0;
    for (i = 0; i < shadow_count; i++) begin
      cmps++;
      if (shadow_slots[i].key == k) return i;
    end
    return -1;
  endfunction

  // Advances the shadow table by one command and returns the response it implies.
  function automatic rsp_t apply_command(req_t r);
    rsp_t      res;
    int        pos, cmps, scratch, lo, hi, mid, i, j;
    slot_rec_t tmp;
    res  = '0;
    pos  = -1;
    cmps = 0;
    case (r.cmd)
      CMD_INSERT: begin
        if (r.key[63:56] == 8'h00) res.status = STAT_INVALID;
        else if (find_linear(r.key, scratch) >= 0) res.status = STAT_DUP;
        else if (shadow_count >= SLOTS) res.status = STAT_FULL;
        else begin
          shadow_slots[shadow_count] = '{key: r.key, tag: r.tag, quantity: r.quantity};
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        pos = find_linear(r.key, scratch);
        if (pos < 0) res.status = STAT_NOTFOUND;
        else begin
          for (i = pos; i < SLOTS - 1; i++) shadow_slots[i] = shadow_slots[i + 1];
          shadow_slots[SLOTS - 1] = '0;
          shadow_count--;
        end
      end
      CMD_SEARCH, CMD_BSEARCH: begin
        if (r.cmd == CMD_SEARCH) pos = find_linear(r.key, cmps);
        else begin
          lo = 0;
          hi = shadow_count - 1;
          while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            cmps++;
            if (shadow_slots[mid].key == r.key) begin
              pos = mid;
              break;
            end
            if (shadow_slots[mid].key > r.key) hi = mid - 1;
            else lo = mid + 1;
          end
        end
        res.compare_count = cmps[4:0];
        if (pos < 0) res.status = STAT_NOTFOUND;
        else begin
          res.found_index    = pos[3:0];
          res.found_tag      = shadow_slots[pos].tag;
          res.found_quantity = shadow_slots[pos].quantity;
        end
      end
      CMD_SORT: begin
        if (shadow_count <= 1) res.status = STAT_NOSORT;
        else begin
          for (i = 0; i + 1 < shadow_count; i++)
            for (j = 0; j + 1 < shadow_count - i; j++)
              if (shadow_slots[j].key > shadow_slots[j + 1].key) begin
                tmp                 = shadow_slots[j];
                shadow_slots[j]     = shadow_slots[j + 1];
                shadow_slots[j + 1] = tmp;
              end
        end
      end
      default: ;  // codes 5..7 leave the table alone
    endcase
    res.entry_count = shadow_count[4:0];
    return res;
  endfunction

  task automatic queue_cmd(logic [2:0] c, logic [63:0] k, logic [63:0] t, logic [31:0] q);
    queued_cmd_t item;
    item.beat  = '{cmd: c, key: k, tag: t, quantity: q};
    item.drain = drain_next || ($urandom_range(49) == 0);
    drain_next = 1'b0;
    cmd_backlog.push_back(item);
    if (c <= CMD_BSEARCH) real_items++;
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Mostly well-formed runs over a small key pool so hits, duplicates and a full table
  // come up often; a slice of raw noise on top.
  task automatic build_phase(int target);
    int start, k, n, sel;
    start      = real_items;
    drain_next = 1'b1;
    while (real_items - start < target) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        n = $urandom_range(18, 4);
        for (k = 0; k < n; k++)
          queue_cmd(CMD_INSERT,
                    ($urandom_range(9) == 0) ? {8'h00, 56'(rand64())} : pool_key(),
                    rand64(), $urandom);
      end else if (sel < 55) begin
        n = $urandom_range(12, 4);
        for (k = 0; k < n; k++)
          queue_cmd($urandom_range(1) ? CMD_SEARCH : CMD_BSEARCH,
                    ($urandom_range(4) == 0) ? rand64() : pool_key(), rand64(), $urandom);
      end else if (sel < 65) begin
        queue_cmd(CMD_SORT, rand64(), rand64(), $urandom);
        n = $urandom_range(8, 3);
        for (k = 0; k < n; k++)
          queue_cmd(CMD_BSEARCH, ($urandom_range(5) == 0) ? rand64() : pool_key(),
                    rand64(), $urandom);
      end else if (sel < 85) begin
        n = $urandom_range(8, 2);
        for (k = 0; k < n; k++)
          queue_cmd(CMD_REMOVE, ($urandom_range(9) == 0) ? rand64() : pool_key(),
                    rand64(), $urandom);
      end else begin
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++)
          queue_cmd(3'($urandom_range(7)), rand64(), rand64(), $urandom);
      end
    end
  endtask

  // Driver: new beat on the falling edge once the previous one has gone.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!req_valid || req_fired) begin
        if (cmd_backlog.size() != 0 && ($urandom_range(99) >= send_idle_pct) &&
            !(cmd_backlog[0].drain && predicted_rsp.size() != 0)) begin
          next_cmd = cmd_backlog.pop_front();
          req       <= next_cmd.beat;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and scoreboard: both channels sampled on the rising edge.
  always @(posedge clk) begin
    req_fired = 1'b0;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (predicted_rsp.size() == 0) begin
          error_count++;
          $display("%0t: response beat with nothing expected, actual %h", $time, rsp);
        end else begin
          want = predicted_rsp.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("found_index", want.found_index, rsp.found_index);
          check_field("compare_count", want.compare_count, rsp.compare_count);
          check_field("found_tag", want.found_tag, rsp.found_tag);
          check_field("found_quantity", want.found_quantity, rsp.found_quantity);
          check_field("entry_count", want.entry_count, rsp.entry_count);
        end
      end
      if (req_valid && !req_stall) begin
        req_fired = 1'b1;
        predicted_rsp.push_back(apply_command(req));
      end
      if ((rsp_valid && !rsp_stall) || req_fired) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** keyed_slot_table_sort_search_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int p;
    for (p = 0; p < POOL_SIZE; p++)
      key_pool[p] = {8'($urandom_range(255, 1)), 56'(rand64())};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, empty keys, extremes of key/tag/quantity, every command
    queue_cmd(CMD_BSEARCH, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    queue_cmd(CMD_SEARCH, 64'h0, '0, '0);
    queue_cmd(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    queue_cmd(CMD_SORT, '0, '0, '0);
    queue_cmd(CMD_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    queue_cmd(CMD_INSERT, 64'h00FF_FFFF_FFFF_FFFF, rand64(), $urandom);
    queue_cmd(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    queue_cmd(CMD_SORT, '0, '0, '0);
    queue_cmd(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    queue_cmd(CMD_INSERT, 64'h0100_0000_0000_0000, 64'h0, 32'h7FFF_FFFF);
    queue_cmd(CMD_INSERT, 64'h4142_4300_0000_0000, rand64(), 32'hFFFF_FFFF);
    queue_cmd(CMD_SEARCH, 64'h0100_0000_0000_0000, '0, '0);
    queue_cmd(CMD_BSEARCH, 64'h0100_0000_0000_0000, '0, '0);
    queue_cmd(CMD_BSEARCH, 64'h4142_4300_0000_0000, '0, '0);  // table still unsorted
    queue_cmd(CMD_SEARCH, 64'h0, '0, '0);
    queue_cmd(CMD_SORT, '0, '0, '0);
    queue_cmd(CMD_BSEARCH, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    queue_cmd(CMD_BSEARCH, 64'h4142_4400_0000_0000, '0, '0);
    queue_cmd(3'd5, rand64(), rand64(), $urandom);
    queue_cmd(3'd6, rand64(), rand64(), $urandom);
    queue_cmd(3'd7, rand64(), rand64(), $urandom);
    queue_cmd(CMD_REMOVE, 64'h0100_0000_0000_0000, '0, '0);
    queue_cmd(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    queue_cmd(CMD_REMOVE, 64'h4142_4300_0000_0000, '0, '0);

    for (p = 0; p < PHASES; p++) begin
      while (cmd_backlog.size() != 0) @(posedge clk);
      send_idle_pct = phase_send_idle[p];
      stall_pct     = phase_stall[p];
      build_phase(PHASE_ITEMS);
    end

    while (cmd_backlog.size() != 0 || req_valid) @(posedge clk);
    while (predicted_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** keyed_slot_table_sort_search_core: PASSED **");
    end else begin
      $display("** keyed_slot_table_sort_search_core: FAILED **");
    end
    $finish;
  end

endmodule

### keyed_slot_table_sort_search_core.f
rtl/core/kst_pkg.sv
rtl/core/kst_ram.sv
rtl/core/keyed_slot_table_sort_search_core.sv
sim/keyed_slot_table_sort_search_core_tb.sv
